[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/fcrt_pkg.sv]
// ---------------------------------------------------------------------------
// Fault code record table package
// Opcodes, status codes and the record and transaction layouts.
// ---------------------------------------------------------------------------
`default_nettype none

package fcrt_pkg;

	localparam int CODE_W        = 32;
	localparam int TIME_W        = 32;
	localparam int COUNT_W       = 16;
	localparam int CFG_IDX_W     = 3;
	localparam int NUM_CODE_REGS = 6;
	localparam int IN_TDATA_W    = 72;
	localparam int OUT_TDATA_W   = 88;

	// Opcodes
	localparam logic [2:0] OP_FAULT     = 3'd0;
	localparam logic [2:0] OP_HEALTHY   = 3'd1;
	localparam logic [2:0] OP_CLEAR     = 3'd2;
	localparam logic [2:0] OP_CLEAR_ALL = 3'd3;
	localparam logic [2:0] OP_QUERY     = 3'd4;

	// Entry status
	localparam logic [1:0] ST_INACTIVE = 2'd0;
	localparam logic [1:0] ST_ACTIVE   = 2'd1;
	localparam logic [1:0] ST_CLEARED  = 2'd2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic [TIME_W-1:0]  last_time;
		logic [TIME_W-1:0]  first_time;
		logic [COUNT_W-1:0] count;
		logic [1:0]         status;
	} rec_t;

	typedef struct packed {
		logic [TIME_W-1:0] time_ms;
		logic [CODE_W-1:0] fault_code;
		logic [2:0]        opcode;
	} in_item_t;

	typedef struct packed {
		logic [TIME_W-1:0]  last_seen_ms;
		logic [TIME_W-1:0]  first_seen_ms;
		logic [COUNT_W-1:0] occurrences;
		logic [1:0]         entry_state;
		logic               is_active;
		logic               found;
	} res_t;

endpackage

`default_nettype wire

[sv/fcrt_code_match.sv]
// ---------------------------------------------------------------------------
// Fault code match
// Holds the per-entry fault codes and finds the lowest entry whose code
// equals the incoming one.
// ---------------------------------------------------------------------------
`default_nettype none

module fcrt_code_match import fcrt_pkg::*; #(
	parameter int ENTRIES = 6,
	parameter int IDX_W   = 3
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [CODE_W-1:0]    cfg_wdata,
	input  wire logic [CODE_W-1:0]    code,
	output logic                      hit,
	output logic [IDX_W-1:0]          idx
);

	logic [CODE_W-1:0] code_q [ENTRIES];

	// Load codes; entries beyond the register list keep their index as code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				code_q[i] <= CODE_W'(i);
			end
		end else begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (i < NUM_CODE_REGS && cfg_we && cfg_idx == CFG_IDX_W'(i)) begin
					code_q[i] <= cfg_wdata;
				end
			end
		end
	end

	// Compare in parallel; lowest matching entry wins
	always_comb begin
		hit = 1'b0;
		idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (code_q[i] == code) begin
				hit = 1'b1;
				idx = IDX_W'(i);
			end
		end
	end

endmodule

`default_nettype wire

[sv/fcrt_record_store.sv]
// ---------------------------------------------------------------------------
// Fault record store
// Synchronous record memory with a registered read port, plus per-entry
// written and wiped flags so that reset and clear-all need no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module fcrt_record_store import fcrt_pkg::*; #(
	parameter int ENTRIES = 6,
	parameter int IDX_W   = 3
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             rd_en,
	input  wire logic [IDX_W-1:0] rd_idx,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_idx,
	input  wire rec_t             wr_rec,
	input  wire logic             clr_all,
	output rec_t                  rd_rec
);

	rec_t               mem [ENTRIES];
	rec_t               rdata_q;
	logic [IDX_W-1:0]   rd_idx_q;
	logic [ENTRIES-1:0] written_q;
	logic [ENTRIES-1:0] wiped_q;
	rec_t               dflt_rec;

	// Memory port: write one entry, read one entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_rec;
		end
		if (rd_en) begin
			rdata_q  <= mem[rd_idx];
			rd_idx_q <= rd_idx;
		end
	end

	// Track which entries hold live data and which were wiped by clear-all
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			wiped_q   <= '0;
		end else if (clr_all) begin
			written_q <= '0;
			wiped_q   <= '1;
		end else if (wr_en) begin
			written_q[wr_idx] <= 1'b1;
		end
	end

	// Entries not written since reset or clear-all read as zero records, with status cleared after clear-all
	always_comb begin
		dflt_rec        = '0;
		dflt_rec.status = wiped_q[rd_idx_q] ? ST_CLEARED : ST_INACTIVE;
		rd_rec          = written_q[rd_idx_q] ? rdata_q : dflt_rec;
	end

endmodule

`default_nettype wire

[sv/fault_code_record_table.sv]
// Fault code record table.
// Results pass stage one, then the output register. Throughput: one
// transaction per cycle unless the output stalls; record memory is read on
// accept, written back as stage one advances, bypassing back-to-back hits.
// Reset: all codes take their entry index, all records read inactive and zero;
// no clearing pass is needed.
// ---------------------------------------------------------------------------
// Fault code record table top level
// Matches the code, reads the record, updates it and writes it back.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fault_code_record_table import fcrt_pkg::*; #(
	parameter int ENTRIES = 6
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// Configuration write port
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic [CODE_W-1:0]      cfg_wdata,
	// Input stream
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// opcode[2:0], fault_code[34:3], time_ms[66:35], zero pad
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// Result stream
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// found[0], is_active[1], entry_state[3:2], occurrences[19:4],
	// first_seen_ms[51:20], last_seen_ms[83:52], zero pad
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	in_item_t          in_item;
	logic              accept;
	logic              m_hit;
	logic [IDX_W-1:0]  m_idx;

	logic              valid_s1;
	logic [2:0]        op_s1;
	logic              hit_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [TIME_W-1:0] time_s1;
	logic              byp_s1;
	rec_t              byp_rec_s1;

	rec_t              store_rec;
	rec_t              cur_rec;
	rec_t              new_rec;
	res_t              res;
	logic              s1_go;
	logic              wr_en;
	logic              clr_all;

	logic              out_valid_q;
	res_t              out_res_q;

	assign in_item = in_item_t'(s_axis_tdata[$bits(in_item_t)-1:0]);

	// Advance the stage when the output register is free or being drained
	assign s1_go         = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || s1_go;
	assign accept        = s_axis_tvalid && s_axis_tready;

	fcrt_code_match #(
		.ENTRIES (ENTRIES),
		.IDX_W   (IDX_W)
	) u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.code      (in_item.fault_code),
		.hit       (m_hit),
		.idx       (m_idx)
	);

	fcrt_record_store #(
		.ENTRIES (ENTRIES),
		.IDX_W   (IDX_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_idx  (m_idx),
		.wr_en   (wr_en),
		.wr_idx  (idx_s1),
		.wr_rec  (new_rec),
		.clr_all (clr_all),
		.rd_rec  (store_rec)
	);

	// Stage one control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the transaction; bypass a write-back to the same entry
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= in_item.opcode;
			hit_s1     <= m_hit;
			idx_s1     <= m_idx;
			time_s1    <= in_item.time_ms;
			byp_s1     <= wr_en && (idx_s1 == m_idx);
			byp_rec_s1 <= new_rec;
		end
	end

	assign cur_rec = byp_s1 ? byp_rec_s1 : store_rec;

	// Apply the operation to the addressed record
	always_comb begin
		new_rec = cur_rec;
		unique case (op_s1)
			OP_FAULT: begin
				if (cur_rec.status != ST_ACTIVE) begin
					if (cur_rec.count == '0) begin
						new_rec.first_time = time_s1;
					end
					if (cur_rec.count != COUNT_MAX) begin
						new_rec.count = cur_rec.count + COUNT_W'(1);
					end
				end
				new_rec.status    = ST_ACTIVE;
				new_rec.last_time = time_s1;
			end
			OP_HEALTHY: begin
				if (cur_rec.status == ST_ACTIVE) begin
					new_rec.status    = ST_INACTIVE;
					new_rec.last_time = time_s1;
				end
			end
			OP_CLEAR: begin
				new_rec        = '0;
				new_rec.status = ST_CLEARED;
			end
			default: begin
				new_rec = cur_rec;
			end
		endcase
	end

	assign wr_en   = s1_go && hit_s1
		&& (op_s1 == OP_FAULT || op_s1 == OP_HEALTHY || op_s1 == OP_CLEAR);
	assign clr_all = s1_go && (op_s1 == OP_CLEAR_ALL);

	// Build the result
	always_comb begin
		res = '0;
		priority if (op_s1 == OP_CLEAR_ALL) begin
			res.found       = 1'b1;
			res.entry_state = ST_CLEARED;
		end else if (hit_s1 && (op_s1 == OP_FAULT || op_s1 == OP_HEALTHY
				|| op_s1 == OP_CLEAR || op_s1 == OP_QUERY)) begin
			res.found         = 1'b1;
			res.is_active     = (new_rec.status == ST_ACTIVE);
			res.entry_state   = new_rec.status;
			res.occurrences   = new_rec.count;
			res.first_seen_ms = new_rec.first_time;
			res.last_seen_ms  = new_rec.last_time;
		end else begin
			res = '0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			out_res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_TDATA_W - $bits(res_t))'(0), out_res_q};

	// Checks
	`ASSERT_SAME(a_stall_blocks_input, valid_s1 && out_valid_q && !m_axis_tready,
		!s_axis_tready, "input accepted while the pipeline is stalled")
	`ASSERT_NEXT(a_clear_all_result, s1_go && op_s1 == OP_CLEAR_ALL,
		out_res_q.found && out_res_q.entry_state == ST_CLEARED,
		"clear-all result not reported as cleared")
	`ASSERT_NEXT(a_miss_result_zero, s1_go && !hit_s1 && op_s1 != OP_CLEAR_ALL,
		out_res_q == '0, "unmatched code produced a non-zero result")
	`ASSERT_SAME(a_active_flag, out_valid_q,
		out_res_q.is_active == (out_res_q.entry_state == ST_ACTIVE),
		"active flag disagrees with entry state")

endmodule

`default_nettype wire
